@@ design/tmse_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the Turing machine engine.
package tmse_pkg;

  localparam int TAPE_CELLS = 256;
  localparam int TAPE_AW    = $clog2(TAPE_CELLS);
  localparam int SLOTS      = 8;
  localparam int SLOT_AW    = $clog2(SLOTS);
  localparam int STATES     = 16;
  localparam int STATE_AW   = $clog2(STATES);
  localparam int SYM_W      = 8;
  localparam int STEP_W     = 32;
  localparam int OP_W       = 3;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 8;

  localparam logic [SYM_W-1:0] BLANK_RESET = SYM_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_SLOT = 3'd0,
    OP_WRITE_CELL = 3'd1,
    OP_STEP       = 3'd2,
    OP_READ_CELL  = 3'd3,
    OP_RESTART    = 3'd4
  } op_t;

  localparam logic [CFG_AW-1:0] CFG_BLANK       = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_START_STATE = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_START_HEAD  = CFG_AW'(2);

  typedef struct packed {
    logic capture;
    logic wr_slot;
    logic wr_cell;
    logic restart;
    logic mem_rd;
    logic step_commit;
    logic take_read;
    logic wr_blank;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            shift;
  } dp_stat_t;

  typedef struct packed {
    logic [SYM_W-1:0]    match;
    logic [SYM_W-1:0]    write_sym;
    logic [STATE_AW-1:0] target;
    logic                right;
  } rule_t;

endpackage

@@ design/tmse_ctrl.sv @@
// Sequencing state machine: walks each transaction through capture, memory access and result.
module tmse_ctrl
  import tmse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EVAL,
    S_BLANK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_WRITE_SLOT: begin
            cmd.wr_slot = 1'b1;
            state_next  = S_FINISH;
          end
          OP_WRITE_CELL: begin
            cmd.wr_cell = 1'b1;
            state_next  = S_FINISH;
          end
          OP_RESTART: begin
            cmd.restart = 1'b1;
            state_next  = S_FINISH;
          end
          OP_STEP, OP_READ_CELL: begin
            cmd.mem_rd = 1'b1;
            state_next = S_EVAL;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_EVAL: begin
        if (stat.op == OP_STEP) begin
          cmd.step_commit = 1'b1;
          state_next      = (stat.hit && stat.shift) ? S_BLANK : S_FINISH;
        end else begin
          cmd.take_read = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_BLANK: begin
        cmd.wr_blank = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        // output register free or draining this cycle
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/tmse_dp.sv @@
// Datapath: tape and rule memories, machine registers, slot match and result register.
module tmse_dp
  import tmse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [OP_W-1:0]     operation,
  input  logic [STATE_AW-1:0] state_index,
  input  logic [SLOT_AW-1:0]  slot_index,
  input  logic                entry_used,
  input  logic [SYM_W-1:0]    match_symbol,
  input  logic [SYM_W-1:0]    new_symbol,
  input  logic [STATE_AW-1:0] target_state,
  input  logic                move_right,
  input  logic [TAPE_AW-1:0]  cell_address,
  input  logic [SYM_W-1:0]    cell_value,
  input  logic                cfg_valid,
  input  logic [CFG_AW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  output logic                halted,
  output logic [STATE_AW-1:0] machine_state,
  output logic [TAPE_AW-1:0]  head_at,
  output logic [SYM_W-1:0]    cell_read,
  output logic [STEP_W-1:0]   steps_done
);

  // captured transaction
  logic [OP_W-1:0]     op_q;
  logic [STATE_AW-1:0] st_q;
  logic [SLOT_AW-1:0]  sl_q;
  logic                used_in_q;
  rule_t               rule_in_q;
  logic [TAPE_AW-1:0]  addr_q;
  logic [SYM_W-1:0]    value_q;

  // machine and configuration
  logic [STATE_AW-1:0] cs;
  logic [TAPE_AW-1:0]  head;
  logic [STEP_W-1:0]   steps;
  logic [TAPE_AW-1:0]  base;
  logic [TAPE_AW-1:0]  blank_addr;
  logic [SYM_W-1:0]    blank_sym;
  logic [STATE_AW-1:0] start_state;
  logic [TAPE_AW-1:0]  start_head;
  logic                halted_q;
  logic [SYM_W-1:0]    rd_q;

  // memories
  logic [STATES-1:0][SLOTS-1:0] used_q;
  rule_t                        rule_mem [STATES][SLOTS];
  rule_t                        rule_row [SLOTS];
  logic [SYM_W-1:0]             tape [TAPE_CELLS];
  logic [SYM_W-1:0]             tape_rd;

  logic [TAPE_AW-1:0] head_phys;
  logic [TAPE_AW-1:0] addr_phys;
  logic [TAPE_AW-1:0] rd_addr;
  logic               hit;
  logic [SLOT_AW-1:0] sel_idx;
  rule_t              sel;
  logic               at_edge;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_wa;
  logic [SYM_W-1:0]   tape_wd;

  // tape is a ring: logical cell i lives at base + i, so an end shift only moves base
  assign head_phys = base + head;
  assign addr_phys = base + addr_q;
  assign rd_addr   = (op_q == OP_STEP) ? head_phys : addr_phys;

  // lowest used slot with a matching symbol wins
  always_comb begin
    hit     = 1'b0;
    sel_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (used_q[cs][s] && (rule_row[s].match == tape_rd)) begin
        hit     = 1'b1;
        sel_idx = SLOT_AW'(s);
      end
    end
  end

  assign sel     = rule_row[sel_idx];
  assign at_edge = sel.right ? (head == TAPE_AW'(TAPE_CELLS - 1)) : (head == '0);

  assign stat.op    = op_q;
  assign stat.hit   = hit;
  assign stat.shift = at_edge;

  always_comb begin
    tape_we = 1'b0;
    tape_wa = addr_phys;
    tape_wd = value_q;
    if (cmd.wr_cell) begin
      tape_we = 1'b1;
    end else if (cmd.step_commit && hit) begin
      tape_we = 1'b1;
      tape_wa = head_phys;
      tape_wd = sel.write_sym;
    end else if (cmd.wr_blank) begin
      tape_we = 1'b1;
      tape_wa = blank_addr;
      tape_wd = blank_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape[tape_wa] <= tape_wd;
    end
    if (cmd.mem_rd) begin
      tape_rd <= tape[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_slot) begin
      rule_mem[st_q][sl_q] <= rule_in_q;
    end
    if (cmd.mem_rd) begin
      rule_row <= rule_mem[cs];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q                <= operation;
      st_q                <= state_index;
      sl_q                <= slot_index;
      used_in_q           <= entry_used;
      rule_in_q.match     <= match_symbol;
      rule_in_q.write_sym <= new_symbol;
      rule_in_q.target    <= target_state;
      rule_in_q.right     <= move_right;
      addr_q              <= cell_address;
      value_q             <= cell_value;
      halted_q            <= 1'b0;
      rd_q                <= '0;
    end
    if (cmd.step_commit) begin
      halted_q   <= !hit;
      // physical cell that receives the blank after a shift
      blank_addr <= sel.right ? base : base - TAPE_AW'(1);
    end
    if (cmd.take_read) begin
      rd_q <= tape_rd;
    end
    if (cmd.load_out) begin
      halted        <= halted_q;
      machine_state <= cs;
      head_at       <= head;
      cell_read     <= rd_q;
      steps_done    <= steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs          <= '0;
      head        <= '0;
      steps       <= '0;
      base        <= '0;
      used_q      <= '0;
      blank_sym   <= BLANK_RESET;
      start_state <= '0;
      start_head  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BLANK:       blank_sym   <= cfg_data[SYM_W-1:0];
          CFG_START_STATE: start_state <= cfg_data[STATE_AW-1:0];
          CFG_START_HEAD:  start_head  <= cfg_data[TAPE_AW-1:0];
          default: ;
        endcase
      end
      if (cmd.wr_slot) begin
        used_q[st_q][sl_q] <= used_in_q;
      end
      if (cmd.restart) begin
        cs    <= start_state;
        head  <= start_head;
        steps <= '0;
      end else if (cmd.step_commit && hit) begin
        cs    <= sel.target;
        steps <= steps + STEP_W'(1);
        if (sel.right) begin
          if (at_edge) begin
            base <= base + TAPE_AW'(1);
          end else begin
            head <= head + TAPE_AW'(1);
          end
        end else begin
          if (at_edge) begin
            base <= base - TAPE_AW'(1);
          end else begin
            head <= head - TAPE_AW'(1);
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_step_count : assert property (@(posedge clk) disable iff (rst)
    (cmd.step_commit && hit) |=> (steps == $past(steps) + STEP_W'(1)))
    else $error("step count did not advance by one on a taken step");

  a_halt_keeps : assert property (@(posedge clk) disable iff (rst)
    (cmd.step_commit && !hit) |=> (cs == $past(cs) && head == $past(head) && base == $past(base)))
    else $error("halting step changed the machine");

  a_blank_after_shift : assert property (@(posedge clk) disable iff (rst)
    cmd.wr_blank |-> $past(cmd.step_commit && hit && at_edge))
    else $error("blank written without a tape shift");

  a_head_or_base : assert property (@(posedge clk) disable iff (rst)
    (cmd.step_commit && hit) |=> (head != $past(head)) != (base != $past(base)))
    else $error("a taken step must move exactly one of head and tape");
`endif

endmodule

@@ design/turing_machine_step_engine.sv @@
// Top level of the single-tape Turing machine step engine.
// One transaction in gives one result out. Slot writes, cell writes, restarts and unknown
// operations go straight from execution to the result; a cell read and a step first read
// the tape, and a step writes a blank into the tape when the head runs off an end.
// The sequence is set by the single-port tape memory with registered read (one read and up
// to two writes per step) and by the output register, which must have room for the result;
// while a result waits there the engine still accepts and works on the next transaction.
// The tape is a ring buffer, so an end shift moves a base pointer instead of the cells.
// Configuration registers: index 0 blank symbol, 1 start state, 2 start head; writes are
// always taken (cfg_ready high) and should only be made while the engine is idle.
module turing_machine_step_engine
  import tmse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [STATE_AW-1:0] state_index,
  input  logic [SLOT_AW-1:0]  slot_index,
  input  logic                entry_used,
  input  logic [SYM_W-1:0]    match_symbol,
  input  logic [SYM_W-1:0]    new_symbol,
  input  logic [STATE_AW-1:0] target_state,
  input  logic                move_right,
  input  logic [TAPE_AW-1:0]  cell_address,
  input  logic [SYM_W-1:0]    cell_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                halted,
  output logic [STATE_AW-1:0] machine_state,
  output logic [TAPE_AW-1:0]  head_at,
  output logic [SYM_W-1:0]    cell_read,
  output logic [STEP_W-1:0]   steps_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_AW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tmse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmse_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .state_index   (state_index),
    .slot_index    (slot_index),
    .entry_used    (entry_used),
    .match_symbol  (match_symbol),
    .new_symbol    (new_symbol),
    .target_state  (target_state),
    .move_right    (move_right),
    .cell_address  (cell_address),
    .cell_value    (cell_value),
    .cfg_valid     (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .halted        (halted),
    .machine_state (machine_state),
    .head_at       (head_at),
    .cell_read     (cell_read),
    .steps_done    (steps_done)
  );

endmodule
